FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PLEX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define PLEX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/plex_pkg.sv
// types, codes and character classes for the punctuation lexer
// no dependencies; used by the core, queue, top and checker through scoped names
package plex_pkg;

  // token kinds on the output
  localparam logic [4:0] KIND_ID     = 5'd0;
  localparam logic [4:0] KIND_INT    = 5'd1;
  localparam logic [4:0] KIND_EQUALS = 5'd2;
  localparam logic [4:0] KIND_ARROW  = 5'd3;
  localparam logic [4:0] KIND_LPAREN = 5'd4;
  localparam logic [4:0] KIND_RPAREN = 5'd5;
  localparam logic [4:0] KIND_LBRACK = 5'd6;
  localparam logic [4:0] KIND_RBRACK = 5'd7;
  localparam logic [4:0] KIND_COLON  = 5'd8;
  localparam logic [4:0] KIND_COMMA  = 5'd9;
  localparam logic [4:0] KIND_LT     = 5'd10;
  localparam logic [4:0] KIND_GT     = 5'd11;
  localparam logic [4:0] KIND_SEMI   = 5'd12;
  localparam logic [4:0] KIND_LBRACE = 5'd13;
  localparam logic [4:0] KIND_RBRACE = 5'd14;
  localparam logic [4:0] KIND_EOF    = 5'd15;
  localparam logic [4:0] KIND_ERROR  = 5'd16;

  // characters with special handling
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_EQ  = 8'h3D;
  localparam logic [7:0] CHAR_GT  = 8'h3E;

  // result queue depth, room for two bursts of two tokens
  localparam int unsigned QDepth = 4;

  // kind of the held piece
  typedef enum logic [1:0] {
    HELD_ID  = 2'd0,
    HELD_INT = 2'd1,
    HELD_EQ  = 2'd2
  } held_kind_e;

  // one result item
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] ch;
    logic       opens;
    logic       closes;
    logic       last;
  } token_t;

  // results of one input byte
  typedef struct packed {
    logic [1:0] cnt;
    token_t     first;
    token_t     second;
  } step_out_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // punctuator kind, KIND_ERROR when the byte is not a punctuator
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h28:   k = KIND_LPAREN;  // (
      8'h29:   k = KIND_RPAREN;  // )
      8'h5B:   k = KIND_LBRACK;  // [
      8'h5D:   k = KIND_RBRACK;  // ]
      8'h3A:   k = KIND_COLON;   // :
      8'h2C:   k = KIND_COMMA;   // ,
      8'h3C:   k = KIND_LT;      // <
      8'h3E:   k = KIND_GT;      // >
      8'h3B:   k = KIND_SEMI;    // ;
      8'h7B:   k = KIND_LBRACE;  // {
      8'h7D:   k = KIND_RBRACE;  // }
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/plex_if.sv
// valid/ready channel interfaces for source bytes and tokens
// depends on nothing
interface plex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface plex_token_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] token_char;
  logic       opens;
  logic       closes;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_char, output opens,
                  output closes, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_char, input opens,
                input closes, input last_of_run, output ready);
endinterface

FILE: rtl/plex_core.sv
// lexer step: holding slot, stop flag and per-byte classification
// depends on plex_pkg
module plex_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  output plex_pkg::step_out_t res_o
);

  logic                 held_valid_q, held_valid_d;
  plex_pkg::held_kind_e held_kind_q, held_kind_d;
  logic [7:0]           held_char_q, held_char_d;
  logic                 held_opens_q, held_opens_d;
  logic                 stopped_q, stopped_d;

  logic                 done;
  logic                 cont;
  logic                 tok_v;
  logic [4:0]           pk;
  plex_pkg::token_t     tok;
  plex_pkg::step_out_t  res;

  // classify the byte after any held token has been dealt with
  always_comb begin
    pk    = plex_pkg::punct_kind(char_i);
    tok_v = 1'b0;
    tok   = '0;
    tok.ch     = char_i;
    tok.opens  = 1'b1;
    tok.closes = 1'b1;
    if (char_i == plex_pkg::CHAR_NUL) begin
      tok_v    = 1'b1;
      tok.kind = plex_pkg::KIND_EOF;
    end else if (char_i == plex_pkg::CHAR_CR || char_i == plex_pkg::CHAR_LF ||
                 char_i == plex_pkg::CHAR_SP || char_i == plex_pkg::CHAR_TAB) begin
      tok_v = 1'b0;
    end else if (plex_pkg::is_letter(char_i) || plex_pkg::is_digit(char_i) ||
                 char_i == plex_pkg::CHAR_EQ) begin
      tok_v = 1'b0;
    end else begin
      tok_v    = 1'b1;
      tok.kind = pk;
    end
  end

  // flush of the held token, then the new byte
  always_comb begin
    held_valid_d = held_valid_q;
    held_kind_d  = held_kind_q;
    held_char_d  = held_char_q;
    held_opens_d = held_opens_q;
    stopped_d    = stopped_q;
    res          = '0;
    done         = 1'b0;
    cont         = 1'b0;
    if (!stopped_q) begin
      if (held_valid_q) begin
        if (held_kind_q == plex_pkg::HELD_EQ) begin
          held_valid_d     = 1'b0;
          res.cnt          = 2'd1;
          res.first.opens  = 1'b1;
          res.first.closes = 1'b1;
          if (char_i == plex_pkg::CHAR_GT) begin
            res.first.kind = plex_pkg::KIND_ARROW;
            res.first.ch   = plex_pkg::CHAR_GT;
            done           = 1'b1;
          end else begin
            res.first.kind = plex_pkg::KIND_EQUALS;
            res.first.ch   = plex_pkg::CHAR_EQ;
          end
        end else begin
          cont = (held_kind_q == plex_pkg::HELD_ID) ? plex_pkg::is_letter(char_i)
                                                    : plex_pkg::is_digit(char_i);
          res.cnt          = 2'd1;
          res.first.kind   = {3'b000, held_kind_q};
          res.first.ch     = held_char_q;
          res.first.opens  = held_opens_q;
          res.first.closes = !cont;
          if (cont) begin
            held_char_d  = char_i;
            held_opens_d = 1'b0;
            done         = 1'b1;
          end else begin
            held_valid_d = 1'b0;
          end
        end
      end
      if (!done) begin
        if (plex_pkg::is_letter(char_i) || plex_pkg::is_digit(char_i)) begin
          held_valid_d = 1'b1;
          held_kind_d  = plex_pkg::is_letter(char_i) ? plex_pkg::HELD_ID
                                                     : plex_pkg::HELD_INT;
          held_char_d  = char_i;
          held_opens_d = 1'b1;
        end else if (char_i == plex_pkg::CHAR_EQ) begin
          held_valid_d = 1'b1;
          held_kind_d  = plex_pkg::HELD_EQ;
          held_char_d  = plex_pkg::CHAR_EQ;
          held_opens_d = 1'b1;
        end
        if (tok_v) begin
          if (res.cnt == 2'd0) begin
            res.first = tok;
          end else begin
            res.second = tok;
          end
          res.cnt = res.cnt + 2'd1;
          if (tok.kind == plex_pkg::KIND_ERROR) begin
            stopped_d = 1'b1;
          end
        end
      end
    end
    // mark the final result of this byte
    if (res.cnt == 2'd1) begin
      res.first.last = 1'b1;
    end
    if (res.cnt == 2'd2) begin
      res.second.last = 1'b1;
    end
  end

  assign res_o = res;

  // lexer state advances on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_kind_q  <= plex_pkg::HELD_ID;
      held_char_q  <= 8'h00;
      held_opens_q <= 1'b0;
      stopped_q    <= 1'b0;
    end else if (step_i) begin
      held_valid_q <= held_valid_d;
      held_kind_q  <= held_kind_d;
      held_char_q  <= held_char_d;
      held_opens_q <= held_opens_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

FILE: rtl/plex_fifo.sv
// result queue taking up to two tokens per cycle and giving one
// depends on plex_pkg
module plex_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  plex_pkg::token_t push0_i,
  input  plex_pkg::token_t push1_i,
  output logic             room_o,
  output logic             pop_valid_o,
  output plex_pkg::token_t pop_data_o,
  input  logic             pop_i
);

  localparam int unsigned PtrW = $clog2(plex_pkg::QDepth);
  localparam int unsigned CntW = $clog2(plex_pkg::QDepth + 1);

  plex_pkg::token_t mem_q [plex_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic [PtrW-1:0]  wr_ptr1;
  logic             pop;

  assign wr_ptr1     = wr_ptr_q + PtrW'(1);
  assign pop         = pop_i && pop_valid_o;
  assign pop_valid_o = count_q != '0;
  assign pop_data_o  = mem_q[rd_ptr_q];
  // room for a full burst of two
  assign room_o      = count_q <= CntW'(plex_pkg::QDepth - 2);

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr1] <= push1_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_cnt_i) - CntW'(pop);
    end
  end

endmodule

FILE: rtl/punctuation_lexer_top.sv
// Punctuation lexer: takes one source byte per transfer and returns tokens, letters
// and digits streamed one piece per character with opens/closes flags. A byte
// lands in an input register, is classified from it against the one-byte holding
// slot, and its zero to two tokens enter a four-entry result queue that drives the
// output. One byte is taken every cycle while the queue has room for two tokens, so
// the sustained rate is one byte per cycle while no byte yields two tokens and the
// sink takes one token per cycle; a byte that yields two tokens (flush plus new
// token) writes both into the queue at once. After an unknown byte the error token
// is the last output until reset.
// depends on plex_pkg, plex_if, plex_core, plex_fifo
module punctuation_lexer_top (
  input  logic clk_i,
  input  logic rst_ni,
  plex_char_if.sink     char_i,
  plex_token_if.source  token_o
);

  logic                s1_valid_q;
  logic [7:0]          s1_char_q;
  logic                room;
  logic                step;
  plex_pkg::step_out_t res;
  plex_pkg::token_t    head;

  assign step         = s1_valid_q && room;
  assign char_i.ready = !s1_valid_q || room;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      s1_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      s1_char_q <= char_i.char_in;
    end
  end

  plex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (s1_char_q),
    .res_o  (res)
  );

  plex_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (step ? res.cnt : 2'd0),
    .push0_i     (res.first),
    .push1_i     (res.second),
    .room_o      (room),
    .pop_valid_o (token_o.valid),
    .pop_data_o  (head),
    .pop_i       (token_o.ready)
  );

  // output payload from the queue head
  assign token_o.token_kind  = head.kind;
  assign token_o.token_char  = head.ch;
  assign token_o.opens       = head.opens;
  assign token_o.closes      = head.closes;
  assign token_o.last_of_run = head.last;

endmodule

FILE: rtl/plex_checker.sv
// port-level checks for the punctuation lexer, bound to the top level
// depends on plex_pkg and assert_macros.svh
`include "assert_macros.svh"

module plex_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] kind_i,
  input logic [7:0] char_i,
  input logic       opens_i,
  input logic       closes_i,
  input logic       last_i
);

  logic        out_xfer;
  logic        out_stall;
  logic        err_xfer;
  logic        run_kind;
  logic [15:0] out_word;

  assign out_xfer  = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign err_xfer  = out_xfer && kind_i == plex_pkg::KIND_ERROR;
  assign run_kind  = kind_i == plex_pkg::KIND_ID || kind_i == plex_pkg::KIND_INT;
  assign out_word  = {kind_i, char_i, opens_i, closes_i, last_i};

  // a stalled token holds
  `PLEX_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_word))

  // nothing follows an error token
  `PLEX_ASSERT_NXT(a_err_final, clk_i, rst_ni, err_xfer, !out_valid_i)

  // an open-ended piece belongs to a run and is the only result of its byte
  `PLEX_ASSERT_IMP(a_piece_cont, clk_i, rst_ni, out_xfer && !closes_i, run_kind && last_i)

  // input only stalls while tokens wait on the output
  `PLEX_ASSERT_IMP(a_in_stall, clk_i, rst_ni, in_valid_i && !in_ready_i, out_valid_i)

  // single-character tokens open and close
  `PLEX_ASSERT_IMP(a_single_char, clk_i, rst_ni, out_valid_i && !run_kind, opens_i && closes_i)

endmodule

bind punctuation_lexer_top plex_checker u_plex_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (char_i.valid),
  .in_ready_i  (char_i.ready),
  .out_valid_i (token_o.valid),
  .out_ready_i (token_o.ready),
  .kind_i      (token_o.token_kind),
  .char_i      (token_o.token_char),
  .opens_i     (token_o.opens),
  .closes_i    (token_o.closes),
  .last_i      (token_o.last_of_run)
);
